### rtl/utrt_pkg.sv
// Shared types, constants and the digit glyph function for the radix text converter.
`timescale 1ns / 1ps
`default_nettype none

package utrt_pkg;

	// Input beat: value to convert and radix selector.
	typedef struct packed {
		logic [15:0] value;
		logic [7:0]  mode;
	} in_t;

	// Output beat: one character or the error marker.
	typedef struct packed {
		logic [7:0] out_char;
		logic       char_valid;
		logic       is_last;
		logic       bad_radix;
		logic [4:0] digit_count;
	} out_t;

	// Radix selector codes.
	localparam logic [7:0] RADIX_BIN = 8'd2;
	localparam logic [7:0] RADIX_OCT = 8'd8;
	localparam logic [7:0] RADIX_DEC = 8'd10;
	localparam logic [7:0] RADIX_HEX = 8'd16;
	localparam logic [7:0] RADIX_MAX = 8'd16;

	// Digit counts of the fixed-width radixes and the longest decimal value.
	localparam logic [4:0] BIN_DIGITS = 5'd16;
	localparam logic [4:0] OCT_DIGITS = 5'd6;
	localparam logic [4:0] HEX_DIGITS = 5'd4;
	localparam logic [4:0] DEC_DIGITS = 5'd5;

	// Prefix characters.
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_B    = 8'h62;
	localparam logic [7:0] CH_O    = 8'h6F;
	localparam logic [7:0] CH_D    = 8'h64;
	localparam logic [7:0] CH_X    = 8'h78;
	localparam logic [7:0] CH_U    = 8'h75;

	// Upper-case ASCII glyph of one digit.
	function automatic logic [7:0] digit_glyph(input logic [3:0] d);
		logic [7:0] g;
		if (d < 4'd10) begin
			g = CH_ZERO + {4'b0, d};
		end else begin
			g = 8'h37 + {4'b0, d};
		end
		return g;
	endfunction

endpackage

`default_nettype wire

### rtl/unsigned_to_radix_text.sv
// Top level of the radix text converter: sequencer, digit shift register and output register.
`timescale 1ns / 1ps
`default_nettype none

// Converts a 16-bit unsigned value to ASCII text in radix 2, 8, 10 or 16.
// The input channel (in_valid, in_ready, in_data) takes one value and radix per
// beat; the output channel (out_valid, out_ready, out_data) gives one character
// per beat: a two-character prefix, then digits most significant first. The
// last beat of each input has is_last set and carries the digit count. A radix
// above sixteen gives a single error beat.
// One input is worked on at a time. Binary, octal and hex digits leave a 20-bit
// shift register one digit per cycle while the output register can take them.
// Decimal first runs a bit-serial BCD conversion, then drops leading zeros,
// keeping at least one digit, then emits the prefix and the remaining digits;
// the dropped and the emitted digits always add up to five.
// in_ready is high while the sequencer is idle; the last beat of one input may
// still wait in the output register while the next input is taken.
// When the receiver stalls, the sequencer holds until the output register
// empties; nothing is dropped. Reset clears the sequencer and output valid.

module unsigned_to_radix_text
	import utrt_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire in_t  in_data,
	output logic      out_valid,
	input  wire logic out_ready,
	output out_t      out_data
);

	// Sequencer states.
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_CONV = 3'd1;
	localparam logic [2:0] S_LEAD = 3'd2;
	localparam logic [2:0] S_PFX0 = 3'd3;
	localparam logic [2:0] S_PFX1 = 3'd4;
	localparam logic [2:0] S_DIG  = 3'd5;
	localparam logic [2:0] S_ERR  = 3'd6;

	// Digit widths of the shift register.
	localparam logic [1:0] K_BIN = 2'd0;
	localparam logic [1:0] K_OCT = 2'd1;
	localparam logic [1:0] K_HEX = 2'd2;

	logic [2:0]  state_q;
	logic [1:0]  kind_q;
	logic [19:0] sh_q;
	logic [4:0]  rem_q;
	logic [4:0]  tot_q;
	logic [7:0]  pfx0_q;
	logic [7:0]  pfx1_q;
	logic        out_valid_q;
	out_t        out_q;

	logic        accept;
	logic        slot_free;
	logic        emit;
	logic        bcd_start;
	logic        bcd_done;
	logic [19:0] bcd;
	logic [3:0]  digit;
	logic [19:0] sh_next;
	logic        last_digit;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;
	assign emit      = slot_free && ((state_q == S_PFX0) || (state_q == S_PFX1)
		|| (state_q == S_DIG) || (state_q == S_ERR));
	assign bcd_start  = accept && (in_data.mode == RADIX_DEC);
	assign last_digit = (rem_q == 5'd1);

	utrt_bcd u_bcd (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (bcd_start),
		.value  (in_data.value),
		.done   (bcd_done),
		.bcd    (bcd)
	);

	// Top digit of the shift register and the register after one digit leaves.
	always_comb begin
		case (kind_q)
			K_BIN: begin
				digit   = {3'b0, sh_q[19]};
				sh_next = {sh_q[18:0], 1'b0};
			end
			K_OCT: begin
				digit   = {1'b0, sh_q[19:17]};
				sh_next = {sh_q[16:0], 3'b0};
			end
			default: begin
				digit   = sh_q[19:16];
				sh_next = {sh_q[15:0], 4'b0};
			end
		endcase
	end

	// Sequencer state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (in_data.mode > RADIX_MAX) begin
							state_q <= S_ERR;
						end else if (in_data.mode == RADIX_DEC) begin
							state_q <= S_CONV;
						end else begin
							state_q <= S_PFX0;
						end
					end
				end
				S_CONV: begin
					if (bcd_done) begin
						state_q <= S_LEAD;
					end
				end
				S_LEAD: begin
					if ((sh_q[19:16] != 4'd0) || (rem_q == 5'd1)) begin
						state_q <= S_PFX0;
					end
				end
				S_PFX0: begin
					if (slot_free) begin
						state_q <= S_PFX1;
					end
				end
				S_PFX1: begin
					if (slot_free) begin
						state_q <= (tot_q == 5'd0) ? S_IDLE : S_DIG;
					end
				end
				S_DIG: begin
					if (slot_free && last_digit) begin
						state_q <= S_IDLE;
					end
				end
				S_ERR: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Per-input data: prefix, digit register and digit counters.
	always_ff @(posedge clk) begin
		if (accept) begin
			pfx0_q <= CH_ZERO;
			kind_q <= K_HEX;
			sh_q   <= {in_data.value, 4'b0};
			case (in_data.mode)
				RADIX_BIN: begin
					pfx1_q <= CH_B;
					kind_q <= K_BIN;
					tot_q  <= BIN_DIGITS;
					rem_q  <= BIN_DIGITS;
				end
				RADIX_OCT: begin
					pfx1_q <= CH_O;
					kind_q <= K_OCT;
					sh_q   <= {2'b0, in_data.value, 2'b0};
					tot_q  <= OCT_DIGITS;
					rem_q  <= OCT_DIGITS;
				end
				RADIX_HEX: begin
					pfx1_q <= CH_X;
					tot_q  <= HEX_DIGITS;
					rem_q  <= HEX_DIGITS;
				end
				RADIX_DEC: begin
					pfx1_q <= CH_D;
					tot_q  <= DEC_DIGITS;
					rem_q  <= DEC_DIGITS;
				end
				default: begin
					pfx0_q <= CH_U;
					pfx1_q <= CH_D;
					tot_q  <= 5'd0;
					rem_q  <= 5'd0;
				end
			endcase
		end else if (state_q == S_CONV) begin
			if (bcd_done) begin
				sh_q <= bcd;
			end
		end else if (state_q == S_LEAD) begin
			// Drop leading zero digits, keeping at least one.
			if ((sh_q[19:16] == 4'd0) && (rem_q != 5'd1)) begin
				sh_q  <= sh_next;
				rem_q <= rem_q - 5'd1;
			end else begin
				tot_q <= rem_q;
			end
		end else if ((state_q == S_DIG) && slot_free) begin
			sh_q  <= sh_next;
			rem_q <= rem_q - 5'd1;
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (emit) begin
			case (state_q)
				S_PFX0: begin
					out_q <= '{out_char: pfx0_q, char_valid: 1'b1, is_last: 1'b0,
						bad_radix: 1'b0, digit_count: 5'd0};
				end
				S_PFX1: begin
					out_q <= '{out_char: pfx1_q, char_valid: 1'b1,
						is_last: (tot_q == 5'd0), bad_radix: 1'b0, digit_count: 5'd0};
				end
				S_DIG: begin
					out_q <= '{out_char: digit_glyph(digit), char_valid: 1'b1,
						is_last: last_digit, bad_radix: 1'b0,
						digit_count: last_digit ? tot_q : 5'd0};
				end
				default: begin
					out_q <= '{out_char: 8'd0, char_valid: 1'b0, is_last: 1'b1,
						bad_radix: 1'b1, digit_count: 5'd0};
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire

### rtl/utrt_bcd.sv
// Bit-serial shift-and-add-three converter from 16-bit binary to five BCD digits.
`timescale 1ns / 1ps
`default_nettype none

module utrt_bcd
	import utrt_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [15:0] value,
	output logic             done,
	output logic [19:0]      bcd
);

	logic [15:0] bin_q;
	logic [19:0] bcd_q;
	logic [3:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [19:0] adj;

	// Add three to every digit of five or more before the next shift.
	always_comb begin
		for (int i = 0; i < 5; i++) begin
			if (bcd_q[4*i +: 4] > 4'd4) begin
				adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end else begin
				adj[4*i +: 4] = bcd_q[4*i +: 4];
			end
		end
	end

	// Control: one value bit enters per cycle, sixteen bits in all.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == 4'd0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 4'd15;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 4'd1;
				if (cnt_q == 4'd0) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Data shift registers.
	always_ff @(posedge clk) begin
		if (start) begin
			bin_q <= value;
			bcd_q <= '0;
		end else if (busy_q) begin
			bin_q <= {bin_q[14:0], 1'b0};
			bcd_q <= {adj[18:0], bin_q[15]};
		end
	end

	assign done = done_q;
	assign bcd  = bcd_q;

endmodule

`default_nettype wire

### tb/sv/utrt_text_checker.sv
// Checker for the radix text converter: predicts the character beats and compares them.
`timescale 1ns / 1ps
`default_nettype none

module utrt_text_checker
	import utrt_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	input  wire logic in_ready,
	input  wire in_t  in_data,
	input  wire logic out_valid,
	input  wire logic out_ready,
	input  wire out_t out_data,
	output int        fail_count,
	output int        pending
);

	localparam logic [7:0] CH_UPPER_A = 8'h41;

	// Character beats still owed by the block, oldest first.
	out_t expected_chars[$];

	initial begin
		fail_count = 0;
		pending = 0;
	end

	// Upper-case ASCII for one digit.
	function automatic logic [7:0] glyph_of(input logic [3:0] d);
		logic [7:0] g;
		if (d < 4'd10) begin
			g = CH_ZERO + 8'(d);
		end else begin
			g = CH_UPPER_A + 8'(d) - 8'd10;
		end
		return g;
	endfunction

	// Queues one character beat.
	function automatic void push_char(input logic [7:0] ch, input logic last,
		input logic [4:0] count);
		out_t r;
		r = '0;
		r.out_char = ch;
		r.char_valid = 1'b1;
		r.is_last = last;
		r.digit_count = count;
		expected_chars.push_back(r);
	endfunction

	// Works out every beat that one input value and radix should produce.
	function automatic void render_radix_text(input in_t beat);
		logic [3:0]  digits [16];
		logic [15:0] v;
		logic [7:0]  lead;
		logic [7:0]  tag;
		logic [15:0] mask;
		int          bits;
		int          n;
		int          i;
		out_t        err;
		v = beat.value;
		lead = CH_ZERO;
		tag = CH_D;
		bits = 0;
		mask = '0;
		n = 0;
		for (i = 0; i < 16; i++) begin
			digits[i] = '0;
		end

		// A radix above sixteen yields a single error beat and nothing else.
		if (beat.mode > RADIX_MAX) begin
			err = '0;
			err.is_last = 1'b1;
			err.bad_radix = 1'b1;
			expected_chars.push_back(err);
			return;
		end

		case (beat.mode)
			RADIX_BIN: begin
				tag = CH_B;
				n = int'(BIN_DIGITS);
				bits = 1;
				mask = 16'h1;
			end
			RADIX_OCT: begin
				tag = CH_O;
				n = int'(OCT_DIGITS);
				bits = 3;
				mask = 16'h7;
			end
			RADIX_HEX: begin
				tag = CH_X;
				n = int'(HEX_DIGITS);
				bits = 4;
				mask = 16'hF;
			end
			RADIX_DEC: begin
				tag = CH_D;
			end
			default: begin
				lead = CH_U;
				tag = CH_D;
			end
		endcase

		// Fixed-width radixes keep their leading zeros.
		if (bits != 0) begin
			for (i = 0; i < n; i++) begin
				digits[i] = 4'((v >> (bits * i)) & mask);
			end
		end

		// Decimal drops leading zeros, but a zero still shows one digit.
		if (beat.mode == RADIX_DEC) begin
			while (v != 16'd0) begin
				digits[n] = 4'(v % 16'd10);
				v = v / 16'd10;
				n++;
			end
			if (n == 0) begin
				digits[0] = 4'd0;
				n = 1;
			end
		end

		push_char(lead, 1'b0, 5'd0);
		if (n == 0) begin
			push_char(tag, 1'b1, 5'd0);
		end else begin
			push_char(tag, 1'b0, 5'd0);
			for (i = n - 1; i >= 0; i--) begin
				push_char(glyph_of(digits[i]), i == 0, (i == 0) ? 5'(n) : 5'd0);
			end
		end
	endfunction

	// Prints one mismatch line and counts it.
	task automatic report_mismatch(input string msg);
		$display("%0d ns: mismatch: %s", $time, msg);
		fail_count = fail_count + 1;
	endtask

	// Compare output beats before predicting, since no input can answer on its own edge.
	always @(posedge clk) begin
		out_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_chars.size() == 0) begin
					report_mismatch($sformatf("unexpected beat char=%h valid=%b last=%b bad=%b cnt=%0d",
						out_data.out_char, out_data.char_valid, out_data.is_last,
						out_data.bad_radix, out_data.digit_count));
				end else begin
					want = expected_chars.pop_front();
					if (out_data.out_char !== want.out_char ||
						out_data.char_valid !== want.char_valid ||
						out_data.is_last !== want.is_last ||
						out_data.bad_radix !== want.bad_radix ||
						out_data.digit_count !== want.digit_count) begin
						report_mismatch($sformatf(
							"got char=%h valid=%b last=%b bad=%b cnt=%0d, want char=%h valid=%b last=%b bad=%b cnt=%0d",
							out_data.out_char, out_data.char_valid, out_data.is_last,
							out_data.bad_radix, out_data.digit_count, want.out_char,
							want.char_valid, want.is_last, want.bad_radix, want.digit_count));
					end
				end
			end
			if (in_valid && in_ready) begin
				render_radix_text(in_data);
			end
		end
		pending = expected_chars.size();
	end

endmodule

`default_nettype wire

### tb/sv/tb_unsigned_to_radix_text.sv
// Testbench top for the radix text converter: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
`default_nettype none

module tb_unsigned_to_radix_text;
	import utrt_pkg::*;

	// Margin allowed after the last beat.
	localparam int TAIL_CYCLES = 64;
	localparam int RANDOM_ITEMS = 135;
	localparam int CALM_ITEMS = 30;
	localparam int CYCLE_LIMIT = 400000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_t  in_data;
	logic out_valid;
	logic out_ready;
	out_t out_data;
	int   fail_count;
	int   pending;
	int   cycle_count;
	logic calm;

	unsigned_to_radix_text dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	utrt_text_checker checker_i (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.fail_count(fail_count),
		.pending   (pending)
	);

	// Free-running clock with a 10 ns period.
	initial begin
		clk = 1'b0;
	end

	always #5 clk = ~clk;

	// Watchdog on the total run length.
	initial begin
		cycle_count = 0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_unsigned_to_radix_text failed");
			$finish;
		end
	end

	// Receiver side: ready stretches broken by stall bursts, steady once calm.
	initial begin
		int run;
		out_ready <= 1'b0;
		forever begin
			if (calm) begin
				out_ready <= 1'b1;
				@(posedge clk);
			end else begin
				run = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 20);
				out_ready <= 1'b1;
				repeat (run) @(posedge clk);
				if (!calm) begin
					out_ready <= 1'b0;
					repeat ($urandom_range(1, 17)) @(posedge clk);
				end
			end
		end
	end

	// Holds one input beat until the block takes it; valid stays up afterwards.
	task automatic send_value(input logic [15:0] v, input logic [7:0] m);
		in_data <= '{value: v, mode: m};
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// Sender gap between beats, skipped once the run is calm.
	task automatic maybe_pause();
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
	endtask

	// Random radix: mostly the four real ones, some unsupported, some out of range.
	function automatic logic [7:0] pick_mode();
		int sel;
		logic [7:0] m;
		sel = $urandom_range(0, 99);
		if (sel < 70) begin
			case ($urandom_range(0, 3))
				0: m = RADIX_BIN;
				1: m = RADIX_OCT;
				2: m = RADIX_DEC;
				default: m = RADIX_HEX;
			endcase
		end else if (sel < 85) begin
			m = 8'($urandom_range(0, 16));
			while (m == RADIX_BIN || m == RADIX_OCT || m == RADIX_DEC || m == RADIX_HEX) begin
				m = 8'($urandom_range(0, 16));
			end
		end else begin
			m = 8'($urandom_range(17, 255));
		end
		return m;
	endfunction

	// Random value spread over full range, small numbers and decimal boundaries.
	function automatic logic [15:0] pick_value();
		int sel;
		logic [15:0] v;
		sel = $urandom_range(0, 99);
		if (sel < 50) begin
			v = 16'($urandom());
		end else if (sel < 70) begin
			v = 16'($urandom_range(0, 99));
		end else if (sel < 85) begin
			case ($urandom_range(0, 3))
				0: v = 16'd9 + 16'($urandom_range(0, 1));
				1: v = 16'd99 + 16'($urandom_range(0, 1));
				2: v = 16'd999 + 16'($urandom_range(0, 1));
				default: v = 16'd9999 + 16'($urandom_range(0, 1));
			endcase
		end else begin
			case ($urandom_range(0, 3))
				0: v = 16'h0000;
				1: v = 16'hFFFF;
				2: v = 16'h8000;
				default: v = 16'h7FFF;
			endcase
		end
		return v;
	endfunction

	// Stimulus and verdict.
	initial begin
		logic [15:0] dir_value [25];
		logic [7:0]  dir_mode [25];
		int i;
		calm = 1'b0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed beats: field extremes, every radix, unsupported and out-of-range modes.
		dir_value = '{16'h0000, 16'hFFFF, 16'hA5A5, 16'h0000, 16'hFFFF, 16'h8000,
			16'h0000, 16'hFFFF, 16'hABCD, 16'd0, 16'd9, 16'd10, 16'd99, 16'd100,
			16'd9999, 16'd10000, 16'd65535, 16'd1234, 16'h0001, 16'h0007, 16'h0005,
			16'h0003, 16'hFFFF, 16'h0000, 16'h0002};
		dir_mode = '{RADIX_BIN, RADIX_BIN, RADIX_BIN, RADIX_OCT, RADIX_OCT, RADIX_OCT,
			RADIX_HEX, RADIX_HEX, RADIX_HEX, RADIX_DEC, RADIX_DEC, RADIX_DEC,
			RADIX_DEC, RADIX_DEC, RADIX_DEC, RADIX_DEC, RADIX_DEC, 8'd0, 8'd1,
			8'd15, 8'd9, 8'd17, 8'd255, 8'd128, 8'd3};
		for (i = 0; i < 25; i++) begin
			send_value(dir_value[i], dir_mode[i]);
			maybe_pause();
		end

		// Random beats; the tail runs without any idling.
		for (i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == RANDOM_ITEMS - CALM_ITEMS) begin
				calm = 1'b1;
			end
			send_value(pick_value(), pick_mode());
			maybe_pause();
		end
		in_valid <= 1'b0;

		// Drain: observe the expectation count away from the clock edge.
		do @(negedge clk); while (pending != 0);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (fail_count == 0) begin
			$display("tb_unsigned_to_radix_text passed");
		end else begin
			$display("tb_unsigned_to_radix_text failed");
		end
		$finish;
	end

endmodule

`default_nettype wire

### filelist.f
rtl/utrt_pkg.sv
rtl/utrt_bcd.sv
rtl/unsigned_to_radix_text.sv
tb/sv/utrt_text_checker.sv
tb/sv/tb_unsigned_to_radix_text.sv
